@@ sv/pbgs_pkg.sv @@
`default_nettype none
package pbgs_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH   = 6;
    localparam int MAG_W        = SAMPLE_WIDTH - 1;
    localparam int PROD_W       = MAG_W + GAIN_WIDTH;
    localparam int CFG_W        = MAG_W;
    localparam int CFG_IDX_W    = 2;
    localparam int MUL_CNT_W    = $clog2(GAIN_WIDTH + 1);
    localparam int DIV_CNT_W    = $clog2(PROD_W + 1);

    localparam logic [MAG_W-1:0]      MAG_MAX       = '1;
    localparam logic [GAIN_WIDTH-1:0] MAX_GAIN_RST  = GAIN_WIDTH'(63);
    localparam logic [MAG_W-1:0]      TARGET_RST    = MAG_W'(1024);
    localparam logic [MAG_W-1:0]      LOWER_RST     = MAG_W'(512);
    localparam logic [MAG_W-1:0]      UPPER_RST     = MAG_W'(1536);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage
`default_nettype wire

@@ sv/pbgs_if.sv @@
`default_nettype none
interface pbgs_item_if
    import pbgs_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic signed [SAMPLE_WIDTH-1:0] amplitude;
    logic [GAIN_WIDTH-1:0]          reported_gain;
    logic                           last;

    modport source (output valid, output op, output amplitude, output reported_gain,
                    output last, input ready);
    modport sink   (input valid, input op, input amplitude, input reported_gain,
                    input last, output ready);
endinterface

interface pbgs_result_if
    import pbgs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [GAIN_WIDTH-1:0] next_step;
    logic                  adjusted;

    modport source (output valid, output next_step, output adjusted, input ready);
    modport sink   (input valid, input next_step, input adjusted, output ready);
endinterface
`default_nettype wire

@@ sv/peak_based_gain_step_control.sv @@
// Amplitude and gain report items: one per cycle while input is not held off, no result.
// Frame end inside the band or with zero gain/peak: result goes to a holding register, then to
// the output register once it is free; input is held off until then.
// Frame end needing a new step: serial multiply, then serial divide, then the holding register;
// input is held off meanwhile. Results sit in an output register.
// rst_n (async, active low) clears gain, peak and handshake state; config regs take defaults.
`default_nettype none
module peak_based_gain_step_control
    import pbgs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    pbgs_item_if.sink                 item,
    pbgs_result_if.source             result,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);

    state_t state_reg, state_next;

    logic [GAIN_WIDTH-1:0] max_gain_reg;
    logic [MAG_W-1:0]      target_reg;
    logic [MAG_W-1:0]      lower_reg;
    logic [MAG_W-1:0]      upper_reg;

    logic [GAIN_WIDTH-1:0] gain_reg, gain_next;
    logic [MAG_W-1:0]      peak_reg, peak_next;
    logic [MAG_W-1:0]      hold_peak_reg, hold_peak_next;
    logic [GAIN_WIDTH-1:0] res_gain_reg, res_gain_next;
    logic                  res_adj_reg, res_adj_next;
    logic                  out_valid_reg, out_valid_next;
    logic [GAIN_WIDTH-1:0] out_gain_reg, out_gain_next;
    logic                  out_adj_reg, out_adj_next;

    logic [SAMPLE_WIDTH-1:0] abs_val;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        frame_peak;
    logic                    outside;
    logic                    xfer;
    logic                    out_free;
    logic                    mul_start;
    logic                    mul_done;
    logic [PROD_W-1:0]       product;
    logic                    div_done;
    logic [PROD_W-1:0]       quotient;

    assign abs_val    = item.amplitude[SAMPLE_WIDTH-1] ? $unsigned(-item.amplitude)
                                                       : $unsigned(item.amplitude);
    // most negative sample saturates
    assign mag        = abs_val[SAMPLE_WIDTH-1] ? MAG_MAX : abs_val[MAG_W-1:0];
    assign frame_peak = (mag > peak_reg) ? mag : peak_reg;
    assign outside    = (frame_peak < lower_reg) || (frame_peak > upper_reg);

    assign item.ready = (state_reg == ST_RUN);
    assign xfer       = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        peak_next      = peak_reg;
        hold_peak_next = hold_peak_reg;
        res_gain_next  = res_gain_reg;
        res_adj_next   = res_adj_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_gain_next  = out_gain_reg;
        out_adj_next   = out_adj_reg;
        mul_start      = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (xfer)
                begin
                    if (item.op == OP_REPORT)
                        gain_next = item.reported_gain;
                    else if (!item.last)
                        peak_next = frame_peak;
                    else
                    begin
                        peak_next      = '0;
                        hold_peak_next = frame_peak;
                        res_adj_next   = outside;
                        state_next     = ST_DONE;
                        if (!outside)
                            res_gain_next = gain_reg;
                        else if (gain_reg == '0)
                            res_gain_next = '0;
                        else if (frame_peak == '0)
                            res_gain_next = max_gain_reg;
                        else
                        begin
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_gain_next = (quotient > PROD_W'(max_gain_reg))
                                    ? max_gain_reg : quotient[GAIN_WIDTH-1:0];
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_gain_next  = res_gain_reg;
                    out_adj_next   = res_adj_reg;
                    state_next     = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            gain_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_peak_reg <= hold_peak_next;
        res_gain_reg  <= res_gain_next;
        res_adj_reg   <= res_adj_next;
        out_gain_reg  <= out_gain_next;
        out_adj_reg   <= out_adj_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gain_reg <= MAX_GAIN_RST;
            target_reg   <= TARGET_RST;
            lower_reg    <= LOWER_RST;
            upper_reg    <= UPPER_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_GAIN: max_gain_reg <= wr_data[GAIN_WIDTH-1:0];
                REG_TARGET:   target_reg   <= wr_data[MAG_W-1:0];
                REG_LOWER:    lower_reg    <= wr_data[MAG_W-1:0];
                REG_UPPER:    upper_reg    <= wr_data[MAG_W-1:0];
                default:      ;
            endcase
        end
    end

    pbgs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (target_reg),
        .mplier  (gain_reg),
        .done    (mul_done),
        .product (product)
    );

    pbgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (product),
        .divisor  (hold_peak_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign result.valid     = out_valid_reg;
    assign result.next_step = out_gain_reg;
    assign result.adjusted  = out_adj_reg;

endmodule
`default_nettype wire

@@ sv/pbgs_mul.sv @@
`default_nettype none
// Shift-and-add multiplier, one multiplier bit per cycle.
module pbgs_mul
    import pbgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [MAG_W-1:0]      mcand,
    input  wire logic [GAIN_WIDTH-1:0] mplier,
    output logic                       done,
    output logic [PROD_W-1:0]          product
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0]     mcand_reg, mcand_next;
    logic [GAIN_WIDTH-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(GAIN_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

@@ sv/pbgs_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module pbgs_div
    import pbgs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [MAG_W-1:0]  divisor,
    output logic                   done,
    output logic [PROD_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    num_reg, num_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [MAG_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     div_reg, div_next;
    logic [MAG_W:0]       trial;
    logic [MAG_W+1:0]     diff;

    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            // remainder stays below the divisor, so it fits in MAG_W bits
            if (!diff[MAG_W+1])
            begin
                rem_next = diff[MAG_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MAG_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ sv/pbgs_checker.sv @@
`default_nettype none
module pbgs_checker
    import pbgs_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire logic                 item_op,
    input wire logic [GAIN_WIDTH-1:0] item_gain,
    input wire logic                 item_last,
    input wire logic                 res_valid,
    input wire logic                 res_ready,
    input wire logic [GAIN_WIDTH-1:0] res_gain,
    input wire logic                 res_adj,
    input wire logic                 wr_en,
    input wire logic [CFG_IDX_W-1:0] wr_index,
    input wire logic [CFG_W-1:0]     wr_data
);

    logic [GAIN_WIDTH-1:0] seen_gain_reg;
    logic [GAIN_WIDTH-1:0] seen_max_reg;
    logic                  frame_end;

    assign frame_end = item_valid && item_ready && (item_op == OP_SAMPLE) && item_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_gain_reg <= '0;
            seen_max_reg  <= MAX_GAIN_RST;
        end
        else
        begin
            if (item_valid && item_ready && (item_op == OP_REPORT))
                seen_gain_reg <= item_gain;
            if (wr_en && (wr_index == REG_MAX_GAIN))
                seen_max_reg <= wr_data[GAIN_WIDTH-1:0];
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_gain) && $stable(res_adj))
        else $error("result changed while stalled");

    a_frame_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> !item_ready && !$rose(res_valid))
        else $error("frame end did not hold off input");

    a_kept_gain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_adj && (!$past(res_valid) || $past(res_ready))
        |-> res_gain == seen_gain_reg)
        else $error("kept gain differs from reported gain");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_adj |-> res_gain <= seen_max_reg)
        else $error("recomputed gain above maximum");

endmodule

bind peak_based_gain_step_control pbgs_checker u_pbgs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_op    (item.op),
    .item_gain  (item.reported_gain),
    .item_last  (item.last),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_gain   (result.next_step),
    .res_adj    (result.adjusted),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
);
`default_nettype wire
